// File: hdl/rndt_pkg.sv
// rndt_pkg: shared types, calendar constants, reciprocal factors and small
// month tables for the next due time pipeline. No dependencies.
package rndt_pkg;

   // pipeline depth, one register per stage
   localparam int NSTG = 18;

   // recurrence units
   localparam logic [2:0] FUNC_DAY   = 3'd1;
   localparam logic [2:0] FUNC_WEEK  = 3'd2;
   localparam logic [2:0] FUNC_MONTH = 3'd3;
   localparam logic [2:0] FUNC_YEAR  = 3'd4;

   localparam longint unsigned DAY_MS     = 64'd86400000;
   localparam longint unsigned DAY_MS_HI  = DAY_MS >> 10;   // 84375, odd part of a day
   localparam longint unsigned MAX_YEAR   = 64'd32767;
   localparam longint unsigned ERA_DAYS   = 64'd146097;    // days in 400 years
   localparam longint unsigned EPOCH_OFS  = 64'd719468;    // 0000-03-01 to 1970-01-01

   // x / D == (x * ceil(2^S / D)) >> S for x < 2^(S - ceil(log2 D))
   localparam int SH_DAY  = 46;   // 29-bit dividend
   localparam int SH_ERA  = 42;   // 24-bit dividend
   localparam int SH_1460 = 29;   // 18-bit dividend
   localparam int SH_365  = 27;   // 18-bit dividend
   localparam int SH_153  = 19;   // 11-bit dividend
   localparam int SH_3    = 32;   // 30-bit dividend
   localparam int SH_100  = 22;   // 15-bit dividend
   localparam int SH_400  = 24;   // 15-bit dividend

   localparam longint unsigned REC_DAY  = ((64'd1 << SH_DAY) + DAY_MS_HI - 1) / DAY_MS_HI;
   localparam longint unsigned REC_ERA  = ((64'd1 << SH_ERA) + ERA_DAYS - 1) / ERA_DAYS;
   localparam longint unsigned REC_1460 = ((64'd1 << SH_1460) + 1459) / 1460;
   localparam longint unsigned REC_365  = ((64'd1 << SH_365) + 364) / 365;
   localparam longint unsigned REC_153  = ((64'd1 << SH_153) + 152) / 153;
   localparam longint unsigned REC_3    = ((64'd1 << SH_3) + 2) / 3;
   localparam longint unsigned REC_100  = ((64'd1 << SH_100) + 99) / 100;
   localparam longint unsigned REC_400  = ((64'd1 << SH_400) + 399) / 400;

   typedef struct packed {
      logic [49:0] due_time_ms;
      logic [2:0]  func;
      logic [30:0] step_count;
   } req_type;

   typedef struct packed {
      logic        result_valid;
      logic [62:0] next_time_ms;
   } rsp_type;

   // days from March 1 to the first of month index mp (0 = March)
   function automatic logic [8:0] cum_days(input logic [3:0] mp);
      logic [8:0] res;
      unique case (mp)
         4'd0:    res = 9'd0;
         4'd1:    res = 9'd31;
         4'd2:    res = 9'd61;
         4'd3:    res = 9'd92;
         4'd4:    res = 9'd122;
         4'd5:    res = 9'd153;
         4'd6:    res = 9'd184;
         4'd7:    res = 9'd214;
         4'd8:    res = 9'd245;
         4'd9:    res = 9'd275;
         4'd10:   res = 9'd306;
         4'd11:   res = 9'd337;
         default: res = 9'd0;
      endcase
      return res;
   endfunction

   function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
      logic [4:0] res;
      unique case (mon)
         4'd2:                      res = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   res = 5'd30;
         default:                   res = 5'd31;
      endcase
      return res;
   endfunction

endpackage

// File: hdl/recurrence_next_due_time.sv
// recurrence_next_due_time: next due instant of a recurring item; uses rndt_pkg.
// Throughput: one transaction per cycle while rsp_stall is low; an 18-stage register
// pipeline, each stage bounded by one reciprocal or constant multiplier.
// Reset (synchronous, active high) clears only the stage valid bits; data registers
// are not reset. Each stage holds only while its successor is full and not moving.
module recurrence_next_due_time (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rndt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rndt_pkg::rsp_type rsp_data
);
   import rndt_pkg::*;

   // Everything one transaction carries down the pipe. Each field is produced
   // at one stage and read at a later one; flops past the last reader are dead.
   typedef struct packed {
      logic [49:0] due;
      logic [2:0]  func;
      logic [30:0] step;
      logic [57:0] p1;        // due[49:22] * REC_DAY
      logic [50:0] dwp;       // day count * 84375
      logic [11:0] q1;        // high quotient digit of the day number
      logic [28:0] x2;        // partial remainder with next 12-bit digit
      logic [62:0] dw_next;   // day/week result
      logic [58:0] p2;
      logic [23:0] z;         // day number shifted to the 0000-03-01 epoch
      logic [26:0] tod;       // time of day in ms
      logic [48:0] pe;
      logic [6:0]  era;
      logic [17:0] doe;       // day of era
      logic [36:0] pa;
      logic [2:0]  cq;        // doe / 36524
      logic        c4;        // last day of the era
      logic [36:0] py;
      logic [8:0]  yoe;
      logic [8:0]  doy;       // day of March-based year
      logic [22:0] pm;
      logic [15:0] yy;
      logic [15:0] y;
      logic [3:0]  m;
      logic [4:0]  d;
      logic [31:0] total;     // months since year 0
      logic [60:0] pt;
      logic [31:0] tyy;       // target year for the year unit
      logic [14:0] ty;
      logic [3:0]  tm;
      logic        ty_ok;
      logic [30:0] p100;
      logic [14:0] yy2;
      logic [30:0] pe2;
      logic [3:0]  mp2;
      logic [8:0]  doy2;
      logic [6:0]  era2;
      logic [8:0]  yoe2;
      logic [17:0] doe2;
      logic [23:0] ebase;
      logic [50:0] pn;
      rsp_type     rsp;
   } stg_type;

   localparam int LAST = NSTG - 1;

   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] vld_in;
   logic [NSTG:0]   rdy;
   stg_type         stg_ff [NSTG];
   stg_type         stg_in [NSTG];

   //--------------------------------------------------------------------------
   // Flow control: a stage loads when it is empty or its successor moves.
   // Bubbles collapse, so input keeps flowing while a result is held.
   //--------------------------------------------------------------------------
   always_comb begin
      rdy[NSTG] = !rsp_stall;
      for (int k = NSTG - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
      vld_in[0] = req_valid;
      for (int k = 1; k < NSTG; k++) begin
         vld_in[k] = vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NSTG; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NSTG; k++) begin
         if (rdy[k]) begin
            stg_ff[k] <= stg_in[k];
         end
      end
   end

   assign req_stall = !rdy[0];
   assign rsp_valid = vld_ff[LAST];
   assign rsp_data  = stg_ff[LAST].rsp;

   //--------------------------------------------------------------------------
   // Datapath. ms -> days: due >> 10 is divided by 84375 in base-4096 digits
   // (top 16 bits are already below the divisor). days -> civil date with the
   // era / year-of-era method, then month or year add with day clamp and back.
   //--------------------------------------------------------------------------
   always_comb begin : datapath
      logic [33:0] n;
      logic [27:0] rem28;
      logic [28:0] rem29;
      logic [11:0] q2;
      logic [23:0] rem24;
      logic [7:0]  a;
      logic [17:0] t;
      logic [1:0]  ycent;
      logic [17:0] sub18;
      logic [10:0] w;
      logic [3:0]  mp;
      logic [8:0]  d9;
      logic [3:0]  mon;
      logic [27:0] tq;
      logic [31:0] rem32;
      logic [31:0] ty32;
      logic [8:0]  q100;
      logic [14:0] r100;
      logic        leap;
      logic [4:0]  last;
      logic [4:0]  td;
      logic [14:0] yoe15;
      logic [1:0]  ycent2;
      logic [23:0] days2;
      logic [50:0] nym;
      logic [62:0] nxt;
      logic        dw;
      logic        ym;
      logic        ok;

      // stage 0: first reciprocal product, day/week span
      n = (req_data.func == FUNC_WEEK)
          ? (34'(req_data.step_count) << 3) - 34'(req_data.step_count)
          : 34'(req_data.step_count);
      stg_in[0]      = '0;
      stg_in[0].due  = req_data.due_time_ms;
      stg_in[0].func = req_data.func;
      stg_in[0].step = req_data.step_count;
      stg_in[0].p1   = 58'(req_data.due_time_ms[49:22]) * 58'(REC_DAY);
      stg_in[0].dwp  = 51'(n) * 51'(DAY_MS_HI);

      // stage 1: high digit and remainder; day/week sum
      stg_in[1]         = stg_ff[0];
      stg_in[1].q1      = stg_ff[0].p1[57:SH_DAY];
      rem28             = stg_ff[0].due[49:22]
                          - 28'(28'(stg_in[1].q1) * 28'(DAY_MS_HI));
      stg_in[1].x2      = {rem28[16:0], stg_ff[0].due[21:10]};
      stg_in[1].dw_next = 63'(stg_ff[0].due) + 63'({stg_ff[0].dwp, 10'b0});

      // stage 2
      stg_in[2]    = stg_ff[1];
      stg_in[2].p2 = 59'(stg_ff[1].x2) * 59'(REC_DAY);

      // stage 3: low digit, time of day, shifted day number
      stg_in[3]     = stg_ff[2];
      q2            = stg_ff[2].p2[57:SH_DAY];
      rem29         = stg_ff[2].x2 - 29'(29'(q2) * 29'(DAY_MS_HI));
      stg_in[3].tod = {rem29[16:0], stg_ff[2].due[9:0]};
      stg_in[3].z   = {stg_ff[2].q1, q2} + 24'(EPOCH_OFS);

      // stage 4
      stg_in[4]    = stg_ff[3];
      stg_in[4].pe = 49'(stg_ff[3].z) * 49'(REC_ERA);

      // stage 5: era and day of era
      stg_in[5]     = stg_ff[4];
      stg_in[5].era = stg_ff[4].pe[48:SH_ERA];
      rem24         = stg_ff[4].z - 24'(24'(stg_in[5].era) * 24'(ERA_DAYS));
      stg_in[5].doe = rem24[17:0];

      // stage 6: leap-cycle corrections
      stg_in[6]    = stg_ff[5];
      stg_in[6].pa = 37'(stg_ff[5].doe) * 37'(REC_1460);
      if (stg_ff[5].doe >= 18'd146096) begin
         stg_in[6].cq = 3'd4;
      end else if (stg_ff[5].doe >= 18'd109572) begin
         stg_in[6].cq = 3'd3;
      end else if (stg_ff[5].doe >= 18'd73048) begin
         stg_in[6].cq = 3'd2;
      end else if (stg_ff[5].doe >= 18'd36524) begin
         stg_in[6].cq = 3'd1;
      end else begin
         stg_in[6].cq = 3'd0;
      end
      stg_in[6].c4 = (stg_ff[5].doe == 18'd146096);

      // stage 7: year of era numerator, times 1/365
      stg_in[7]    = stg_ff[6];
      a            = stg_ff[6].pa[36:SH_1460];
      t            = stg_ff[6].doe - 18'(a) + 18'(stg_ff[6].cq) - 18'(stg_ff[6].c4);
      stg_in[7].py = 37'(t) * 37'(REC_365);

      // stage 8: year of era, day of year
      stg_in[8]     = stg_ff[7];
      stg_in[8].yoe = stg_ff[7].py[35:SH_365];
      if (stg_in[8].yoe >= 9'd300) begin
         ycent = 2'd3;
      end else if (stg_in[8].yoe >= 9'd200) begin
         ycent = 2'd2;
      end else if (stg_in[8].yoe >= 9'd100) begin
         ycent = 2'd1;
      end else begin
         ycent = 2'd0;
      end
      sub18 = stg_ff[7].doe - (18'(stg_in[8].yoe) * 18'd365
                               + 18'(stg_in[8].yoe[8:2]) - 18'(ycent));
      stg_in[8].doy = sub18[8:0];

      // stage 9: month index product, March-based year
      stg_in[9]    = stg_ff[8];
      w            = 11'(stg_ff[8].doy) * 11'd5 + 11'd2;
      stg_in[9].pm = 23'(w) * 23'(REC_153);
      stg_in[9].yy = 16'(stg_ff[8].yoe) + 16'(stg_ff[8].era) * 16'd400;

      // stage 10: civil year, month, day
      stg_in[10]   = stg_ff[9];
      mp           = stg_ff[9].pm[22:SH_153];
      d9           = stg_ff[9].doy - cum_days(mp) + 9'd1;
      stg_in[10].d = d9[4:0];
      mon          = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
      stg_in[10].m = mon;
      stg_in[10].y = stg_ff[9].yy + 16'(mon <= 4'd2);

      // stage 11: month total, total / 12 as (total / 4) / 3
      stg_in[11]       = stg_ff[10];
      stg_in[11].total = 32'(stg_ff[10].y) * 32'd12 + 32'(stg_ff[10].m) - 32'd1
                         + 32'(stg_ff[10].step);
      stg_in[11].pt    = 61'(stg_in[11].total[31:2]) * 61'(REC_3);
      stg_in[11].tyy   = 32'(stg_ff[10].y) + 32'(stg_ff[10].step);

      // stage 12: target year and month; range check
      stg_in[12] = stg_ff[11];
      tq         = stg_ff[11].pt[59:SH_3];
      rem32      = stg_ff[11].total - 32'(tq) * 32'd12;
      if (stg_ff[11].func == FUNC_MONTH) begin
         ty32          = 32'(tq);
         stg_in[12].tm = rem32[3:0] + 4'd1;
      end else begin
         ty32          = stg_ff[11].tyy;
         stg_in[12].tm = stg_ff[11].m;
      end
      stg_in[12].ty    = ty32[14:0];
      stg_in[12].ty_ok = (ty32 <= 32'(MAX_YEAR));

      // stage 13: century product, back-conversion year and era product
      stg_in[13]      = stg_ff[12];
      stg_in[13].p100 = 31'(stg_ff[12].ty) * 31'(REC_100);
      stg_in[13].yy2  = (stg_ff[12].tm <= 4'd2) ? stg_ff[12].ty - 15'd1 : stg_ff[12].ty;
      stg_in[13].pe2  = 31'(stg_in[13].yy2) * 31'(REC_400);
      stg_in[13].mp2  = (stg_ff[12].tm > 4'd2) ? stg_ff[12].tm - 4'd3
                                               : stg_ff[12].tm + 4'd9;

      // stage 14: leap year, clamp day, day of year, year of era
      stg_in[14] = stg_ff[13];
      q100       = stg_ff[13].p100[30:SH_100];
      r100       = stg_ff[13].ty - 15'(15'(q100) * 15'd100);
      leap       = ((stg_ff[13].ty[1:0] == 2'd0) && (r100 != 15'd0))
                   || ((r100 == 15'd0) && (q100[1:0] == 2'd0));
      last       = month_days(stg_ff[13].tm, leap);
      td         = (stg_ff[13].d > last) ? last : stg_ff[13].d;
      stg_in[14].doy2 = cum_days(stg_ff[13].mp2) + 9'(td) - 9'd1;
      stg_in[14].era2 = stg_ff[13].pe2[30:SH_400];
      yoe15           = stg_ff[13].yy2 - 15'(15'(stg_in[14].era2) * 15'd400);
      stg_in[14].yoe2 = yoe15[8:0];

      // stage 15: day of era, era base
      stg_in[15] = stg_ff[14];
      if (stg_ff[14].yoe2 >= 9'd300) begin
         ycent2 = 2'd3;
      end else if (stg_ff[14].yoe2 >= 9'd200) begin
         ycent2 = 2'd2;
      end else if (stg_ff[14].yoe2 >= 9'd100) begin
         ycent2 = 2'd1;
      end else begin
         ycent2 = 2'd0;
      end
      stg_in[15].doe2  = 18'(stg_ff[14].yoe2) * 18'd365 + 18'(stg_ff[14].yoe2[8:2])
                         - 18'(ycent2) + 18'(stg_ff[14].doy2);
      stg_in[15].ebase = 24'(stg_ff[14].era2) * 24'(ERA_DAYS);

      // stage 16: days since 1970, scaled to ms
      stg_in[16]    = stg_ff[15];
      days2         = stg_ff[15].ebase + 24'(stg_ff[15].doe2) - 24'(EPOCH_OFS);
      stg_in[16].pn = 51'(days2) * 51'(DAY_MS);

      // stage 17: select, validity, output register
      stg_in[17] = stg_ff[16];
      nym        = stg_ff[16].pn + 51'(stg_ff[16].tod);
      dw         = (stg_ff[16].func == FUNC_DAY) || (stg_ff[16].func == FUNC_WEEK);
      ym         = (stg_ff[16].func == FUNC_MONTH) || (stg_ff[16].func == FUNC_YEAR);
      nxt        = dw ? stg_ff[16].dw_next : (ym ? 63'(nym) : '0);
      ok         = (stg_ff[16].due != '0) && (stg_ff[16].step != '0)
                   && (dw || (ym && stg_ff[16].ty_ok))
                   && (nxt > 63'(stg_ff[16].due));
      stg_in[17].rsp.result_valid = ok;
      stg_in[17].rsp.next_time_ms = ok ? nxt : '0;
   end

`ifndef SYNTH
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.result_valid |-> rsp_data.next_time_ms == '0)
      else $error("invalid result with nonzero time");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&vld_ff) && rsp_stall)
      else $error("input stalled with a bubble in the pipe");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      vld_ff[5] && !rdy[6] |=> vld_ff[5] && $stable(stg_ff[5].doe))
      else $error("blocked stage lost or changed its transaction");

   a_date_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[10] |-> stg_ff[10].m >= 4'd1 && stg_ff[10].m <= 4'd12
                     && stg_ff[10].d >= 5'd1 && stg_ff[10].d <= 5'd31)
      else $error("decoded date out of range");

   a_tod_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] |-> stg_ff[3].tod < 27'(DAY_MS))
      else $error("time of day not below one day");
`endif

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench for recurrence_next_due_time; needs rndt_pkg and the RTL.
// A queue-fed driver and a clocked monitor; expected next due times are predicted
// per accepted transaction and matched in order against the response channel.
module testbench;
   import rndt_pkg::*;

   // unit codes the package leaves out: none, and the unused top codes
   localparam logic [2:0] FUNC_NONE       = 3'd0;
   localparam logic [2:0] FUNC_RSVD_FIRST = 3'd5;
   localparam logic [2:0] FUNC_RSVD_LAST  = 3'd7;
   localparam longint unsigned WEEK_LEN   = 64'd7;

   localparam int RANDOM_ITEMS = 1130;
   localparam int TAIL_ITEMS   = 150;   // no idling on either side for the last ones
   localparam int DRAIN_AT     = 700;   // sender waits for an empty pipe before this one
   localparam int LONG_HOLD_AT = 400;   // accepted count that triggers the long rsp stall
   localparam int LONG_HOLD    = 150;
   localparam int PIPE_DEPTH   = 18;
   localparam int QUIET_LIMIT  = 3000;
   localparam int PRINT_CAP    = 200;

   typedef struct packed {
      req_type    payload;
      logic [4:0] gap;          // idle cycles before this transaction is offered
      logic       drain_first;  // hold it back until nothing is outstanding
   } stim_item_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   stim_item_type req_backlog[$];
   rsp_type       due_expected[$];
   logic          req_taken = 1'b0;   // set at the edge where the offered transaction went in
   int unsigned   accepted_reqs = 0;
   int unsigned   item_total = 0;
   int unsigned   mismatches = 0;
   int unsigned   quiet_cycles = 0;
   int unsigned   gap_left = 0;
   int unsigned   hold_left = 0;
   bit            long_hold_done = 1'b0;

   recurrence_next_due_time u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Calendar arithmetic, proleptic Gregorian
   // ---------------------------------------------------------------------------
   function automatic longint unsigned month_len(longint unsigned yr, longint unsigned mo);
      bit leap;
      leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
      case (mo)
         2:           return leap ? 29 : 28;
         4, 6, 9, 11: return 30;
         default:     return 31;
      endcase
   endfunction

   // days since 1970-01-01; years from 1970 on only
   function automatic longint unsigned date_to_days(longint unsigned yr, longint unsigned mo,
                                                    longint unsigned dy);
      longint unsigned y_adj, era, yoe, mp, doy, doe;
      y_adj = (mo <= 2) ? yr - 1 : yr;   // years start in March
      era   = y_adj / 400;
      yoe   = y_adj - era * 400;
      mp    = (mo > 2) ? mo - 3 : mo + 9;
      doy   = (153 * mp + 2) / 5 + dy - 1;
      doe   = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      return era * 146097 + doe - 719468;
   endfunction

   function automatic logic [49:0] stamp(longint unsigned yr, longint unsigned mo,
                                         longint unsigned dy, longint unsigned tod);
      longint unsigned ms;
      ms = date_to_days(yr, mo, dy) * DAY_MS + tod;
      return ms[49:0];
   endfunction

   // Expected response for one request transaction.
   function automatic rsp_type predict_next_due(req_type r);
      longint unsigned due, step, next, days, tod, z, era, doe, yoe, doy, mp;
      longint unsigned yr, mo, dy, ty, tm, total, last;
      bit      ok;
      rsp_type res;
      due  = 64'(r.due_time_ms);
      step = 64'(r.step_count);
      next = 0;
      ok   = 1'b0;
      if (due != 0 && step != 0) begin
         case (r.func)
            FUNC_DAY, FUNC_WEEK: begin
               next = due + ((r.func == FUNC_WEEK) ? step * WEEK_LEN : step) * DAY_MS;
               ok   = 1'b1;
            end
            FUNC_MONTH, FUNC_YEAR: begin
               days = due / DAY_MS;
               tod  = due - days * DAY_MS;
               // split the day count into a civil date
               z    = days + 719468;
               era  = z / 146097;
               doe  = z - era * 146097;
               yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
               doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
               mp   = (5 * doy + 2) / 153;
               dy   = doy - (153 * mp + 2) / 5 + 1;
               mo   = (mp < 10) ? mp + 3 : mp - 9;
               yr   = yoe + era * 400 + ((mo <= 2) ? 1 : 0);
               if (yr <= MAX_YEAR) begin
                  if (r.func == FUNC_MONTH) begin
                     total = yr * 12 + (mo - 1) + step;
                     ty    = total / 12;
                     tm    = total % 12 + 1;
                  end else begin
                     ty = yr + step;
                     tm = mo;
                  end
                  if (ty <= MAX_YEAR) begin
                     last = month_len(ty, tm);
                     if (dy > last) dy = last;   // clamp to the end of a shorter month
                     next = date_to_days(ty, tm, dy) * DAY_MS + tod;
                     ok   = 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end
      if (ok && next <= due) ok = 1'b0;
      if (!ok) next = 0;
      res.result_valid = ok;
      res.next_time_ms = next[62:0];
      return res;
   endfunction

   task automatic push_item(logic [49:0] due, logic [2:0] fn, logic [30:0] step,
                            int unsigned gap, bit drain);
      stim_item_type it;
      it.payload.due_time_ms = due;
      it.payload.func        = fn;
      it.payload.step_count  = step;
      it.gap                 = gap[4:0];
      it.drain_first         = drain;
      req_backlog.push_back(it);
   endtask

   // ---------------------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------------------
   initial begin : stimulus
      logic [63:0]     wide;
      logic [49:0]     due;
      logic [49:0]     year_end;
      logic [2:0]      fn;
      logic [30:0]     step;
      longint unsigned yr, mo, dy, tod;
      int unsigned     gap, pick;
      reset = 1'b1;

      year_end = stamp(32768, 1, 1, 0);   // first ms past the last allowed year

      // directed: field extremes, every unit, clamping and range edges
      push_item(50'd1, FUNC_DAY, 31'd1, 0, 0);
      push_item('1, FUNC_DAY, '1, 0, 0);
      push_item('1, FUNC_WEEK, '1, 0, 0);
      push_item(50'd0, FUNC_DAY, 31'd5, 0, 0);                // zero due time
      push_item(stamp(2024, 5, 5, 1000), FUNC_WEEK, 31'd0, 0, 0);   // zero step
      push_item(stamp(2024, 5, 5, 1000), FUNC_NONE, 31'd3, 0, 0);
      for (int c = FUNC_RSVD_FIRST; c <= FUNC_RSVD_LAST; c++)
         push_item(stamp(2024, 5, 5, 1000), c[2:0], 31'd3, 0, 0);
      push_item(stamp(2024, 1, 31, 45296789), FUNC_MONTH, 31'd1, 0, 0);  // to Feb 29
      push_item(stamp(2023, 1, 31, 45296789), FUNC_MONTH, 31'd1, 0, 0);  // to Feb 28
      push_item(stamp(2024, 2, 29, 3600000), FUNC_YEAR, 31'd1, 0, 0);
      push_item(stamp(2000, 2, 29, 0), FUNC_YEAR, 31'd100, 0, 0);       // 2100 not leap
      push_item(stamp(2021, 3, 31, 7), FUNC_MONTH, 31'd1, 0, 0);         // to Apr 30
      push_item(stamp(2023, 12, 15, 99), FUNC_MONTH, 31'd1, 0, 0);       // year wrap
      push_item(stamp(1999, 12, 31, DAY_MS - 1), FUNC_MONTH, 31'd2, 0, 0);
      push_item(year_end - 50'd1, FUNC_DAY, 31'd1, 0, 0);
      push_item(year_end - 50'd1, FUNC_MONTH, 31'd1, 0, 0);  // target past the last year
      push_item(stamp(32767, 11, 30, 5), FUNC_MONTH, 31'd1, 0, 0);
      push_item(year_end, FUNC_YEAR, 31'd1, 0, 0);         // source past the last year
      push_item(stamp(2000, 6, 15, 12), FUNC_YEAR, 31'd30767, 0, 0);  // lands on the last year
      push_item(50'd1, FUNC_MONTH, 31'd1, 0, 0);
      push_item(50'd1, FUNC_YEAR, '1, 0, 0);
      push_item(50'd1, FUNC_MONTH, '1, 0, 0);
      push_item('1, FUNC_MONTH, 31'd1, 0, 0);

      // random part; most dates are real calendar dates so the month logic is exercised
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0, 1: begin
               wide = {$urandom, $urandom};
               due  = wide[49:0];
            end
            2, 3, 4, 5, 6, 7: begin
               tod = 64'($urandom_range(0, 32'(DAY_MS - 1)));
               if (pick <= 4) begin
                  yr = 64'($urandom_range(1970, 2400));
                  mo = 64'($urandom_range(1, 12));
                  dy = 64'($urandom_range(1, 32'(month_len(yr, mo))));
               end else if (pick <= 6) begin
                  // month ends, where clamping happens
                  yr = 64'($urandom_range(1970, 9999));
                  mo = 64'($urandom_range(1, 12));
                  dy = month_len(yr, mo) - 64'($urandom_range(0, 3));
               end else begin
                  yr = 64'($urandom_range(32760, 32767));
                  mo = 64'($urandom_range(1, 12));
                  dy = 64'($urandom_range(1, 32'(month_len(yr, mo))));
               end
               due = stamp(yr, mo, dy, tod);
            end
            8:       due = 50'($urandom_range(0, 100000000));
            default: due = year_end - 50'($urandom_range(0, 200000000)) + 50'd100000000;
         endcase

         pick = $urandom_range(0, 19);
         if (pick == 0)       fn = FUNC_NONE;
         else if (pick == 1)  fn = 3'($urandom_range(FUNC_RSVD_FIRST, FUNC_RSVD_LAST));
         else if (pick <= 5)  fn = FUNC_DAY;
         else if (pick <= 8)  fn = FUNC_WEEK;
         else if (pick <= 14) fn = FUNC_MONTH;
         else                 fn = FUNC_YEAR;

         pick = $urandom_range(0, 9);
         case (pick)
            0, 1, 2, 3, 4: step = 31'($urandom_range(1, 36));
            5, 6:          step = 31'($urandom_range(1, 50000));
            7:             step = 31'($urandom);
            8:             step = 31'(12 * $urandom_range(1, 200));
            default: begin
               pick = $urandom_range(0, 2);
               step = (pick == 0) ? 31'd0 : (pick == 1) ? 31'd1 : '1;
            end
         endcase

         // sender gaps come in bursts, with calm stretches and a calm tail
         gap = 0;
         if (n < RANDOM_ITEMS - TAIL_ITEMS && (n / 64) % 3 != 2 && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 16);
         push_item(due, fn, step, gap, n == DRAIN_AT);
      end
      item_total = req_backlog.size();

      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (req_backlog.size() != 0 || req_valid || due_expected.size() != 0)
         @(negedge clock);
      // let any stray response show up before the verdict
      repeat (PIPE_DEPTH + 12) @(posedge clock);
      if (mismatches == 0 && due_expected.size() == 0 && req_backlog.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Driver: request side, changes on the falling edge
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin : driver
      if (!reset && (!req_valid || req_taken)) begin
         if (gap_left > 0) begin
            gap_left  = gap_left - 1;
            req_valid <= 1'b0;
         end else if (req_backlog.size() != 0 &&
                      !(req_backlog[0].drain_first && due_expected.size() != 0)) begin
            req_data  <= req_backlog[0].payload;
            req_valid <= 1'b1;
            void'(req_backlog.pop_front());
            if (req_backlog.size() != 0)
               gap_left = 32'(req_backlog[0].gap);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response back-pressure: random bursts, one long hold to fill the pipe,
   // none once the tail of the run is reached.
   always @(negedge clock) begin : rsp_pace
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
      end else if (!long_hold_done && accepted_reqs >= LONG_HOLD_AT) begin
         long_hold_done = 1'b1;
         hold_left      = LONG_HOLD - 1;
         rsp_stall      <= 1'b1;
      end else if (accepted_reqs + TAIL_ITEMS >= item_total) begin
         rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
         hold_left = $urandom_range(1, 16) - 1;
         rsp_stall <= 1'b1;
      end else begin
         hold_left = $urandom_range(0, 40);
         rsp_stall <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: samples both channels on the rising edge. The response is
   // checked before the new request transaction is predicted, so a response
   // with nothing outstanding can't be matched to a same-edge request.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      rsp_type want;
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (due_expected.size() == 0) begin
               mismatches = mismatches + 1;
               if (mismatches <= PRINT_CAP)
                  $display("%0t: response with nothing outstanding: valid=%0b time=%0d",
                           $time, rsp_data.result_valid, rsp_data.next_time_ms);
            end else begin
               want = due_expected.pop_front();
               if (rsp_data.result_valid !== want.result_valid ||
                   rsp_data.next_time_ms !== want.next_time_ms) begin
                  mismatches = mismatches + 1;
                  if (mismatches <= PRINT_CAP)
                     $display("%0t: mismatch: expected valid=%0b time=%0d, got valid=%0b time=%0d",
                              $time, want.result_valid, want.next_time_ms,
                              rsp_data.result_valid, rsp_data.next_time_ms);
               end
            end
         end
         if (req_valid && !req_stall) begin
            due_expected.push_back(predict_next_due(req_data));
            accepted_reqs = accepted_reqs + 1;
         end

         // watchdog: cycles with no transaction on either channel
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: timeout, %0d transactions outstanding", $time, due_expected.size());
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

endmodule

// File: recurrence_next_due_time.f
hdl/rndt_pkg.sv
hdl/recurrence_next_due_time.sv
tb/testbench.sv
